@@ rtl/core/tml_pkg.sv @@
// shared types, codes and helper functions for the template markup lexer
`default_nettype none
package tml_pkg;

	localparam int LINE_BITS_DEF = 16;
	localparam int INT_BITS_DEF  = 32;
	localparam int FIFO_DEPTH    = 4;
	localparam int MAX_RES       = 3;

	typedef enum logic [3:0] {
		M_TEXT    = 4'd0,
		M_TEXT_LT = 4'd1,
		M_ESC     = 4'd2,
		M_COMMENT = 4'd3,
		M_VERB    = 4'd4,
		M_EXPR    = 4'd5,
		M_OP      = 4'd6,
		M_QUOTE   = 4'd7,
		M_DEC     = 4'd8,
		M_FRAC    = 4'd9,
		M_HEX     = 4'd10,
		M_ID      = 4'd11,
		M_HALT    = 4'd12
	} mode_t;

	typedef enum logic [0:0] {
		CFG_IGNORE_EOF   = 1'b0,
		CFG_SINGLE_STATE = 1'b1
	} cfg_idx_t;

	localparam logic [5:0] K_TEXT   = 6'd0;
	localparam logic [5:0] K_ESC    = 6'd1;
	localparam logic [5:0] K_VERB   = 6'd2;
	localparam logic [5:0] K_LT     = 6'd3;
	localparam logic [5:0] K_GT     = 6'd4;
	localparam logic [5:0] K_SHR    = 6'd5;
	localparam logic [5:0] K_GE     = 6'd6;
	localparam logic [5:0] K_SHL    = 6'd7;
	localparam logic [5:0] K_LE     = 6'd8;
	localparam logic [5:0] K_PLUS   = 6'd9;
	localparam logic [5:0] K_MINUS  = 6'd10;
	localparam logic [5:0] K_SLASH  = 6'd11;
	localparam logic [5:0] K_PCT    = 6'd12;
	localparam logic [5:0] K_STAR   = 6'd13;
	localparam logic [5:0] K_QMARK  = 6'd14;
	localparam logic [5:0] K_SCOPE  = 6'd15;
	localparam logic [5:0] K_COLON  = 6'd16;
	localparam logic [5:0] K_COMMA  = 6'd17;
	localparam logic [5:0] K_EQ     = 6'd18;
	localparam logic [5:0] K_ASSIGN = 6'd19;
	localparam logic [5:0] K_NE     = 6'd20;
	localparam logic [5:0] K_NOT    = 6'd21;
	localparam logic [5:0] K_LAND   = 6'd22;
	localparam logic [5:0] K_AND    = 6'd23;
	localparam logic [5:0] K_LOR    = 6'd24;
	localparam logic [5:0] K_OR     = 6'd25;
	localparam logic [5:0] K_DOT    = 6'd26;
	localparam logic [5:0] K_LPAREN = 6'd27;
	localparam logic [5:0] K_RPAREN = 6'd28;
	localparam logic [5:0] K_LBRACK = 6'd29;
	localparam logic [5:0] K_RBRACK = 6'd30;
	localparam logic [5:0] K_LBRACE = 6'd31;
	localparam logic [5:0] K_RBRACE = 6'd32;
	localparam logic [5:0] K_ID     = 6'd33;
	localparam logic [5:0] K_STR    = 6'd34;
	localparam logic [5:0] K_BOOL   = 6'd35;
	localparam logic [5:0] K_INT    = 6'd36;
	localparam logic [5:0] K_FLOAT  = 6'd37;
	localparam logic [5:0] K_DONE   = 6'd38;
	localparam logic [5:0] K_ERR    = 6'd39;

	localparam logic [3:0] E_NONE    = 4'd0;
	localparam logic [3:0] E_ESC     = 4'd1;
	localparam logic [3:0] E_COMMENT = 4'd2;
	localparam logic [3:0] E_VERB    = 4'd3;
	localparam logic [3:0] E_LT      = 4'd4;
	localparam logic [3:0] E_ID      = 4'd5;
	localparam logic [3:0] E_STR     = 4'd6;
	localparam logic [3:0] E_NUM     = 4'd7;
	localparam logic [3:0] E_CHAR    = 4'd8;
	localparam logic [3:0] E_EOF     = 4'd9;

	localparam logic [1:0] W_NONE  = 2'd0;
	localparam logic [1:0] W_TRUE  = 2'd1;
	localparam logic [1:0] W_FALSE = 2'd2;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (c inside {["0":"9"]}) v = c[3:0];
		else v = 4'(c[3:0] + 4'd9);
		return v;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"], "_"});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {["0":"9"]});
	endfunction

	// letter of true or false at a position
	function automatic logic [7:0] word_char(input logic [1:0] sel, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		if (sel == W_TRUE) begin
			case (pos)
				3'd1: ch = "r";
				3'd2: ch = "u";
				3'd3: ch = "e";
				default: ch = 8'h00;
			endcase
		end else begin
			case (pos)
				3'd1: ch = "a";
				3'd2: ch = "l";
				3'd3: ch = "s";
				3'd4: ch = "e";
				default: ch = 8'h00;
			endcase
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/tml_if.sv @@
// channel interfaces: byte input, token output and configuration write
`default_nettype none
interface tml_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;
	modport source (output valid, in_byte, end_of_input, input ready);
	modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface tml_out_if #(
	parameter int INT_BITS  = 32,
	parameter int LINE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [5:0]           token_kind;
	logic [7:0]           token_byte;
	logic                 byte_valid;
	logic                 token_last;
	logic [INT_BITS-1:0]  int_value;
	logic [LINE_BITS-1:0] start_row;
	logic [LINE_BITS-1:0] start_column;
	logic [3:0]           error_code;
	modport source (output valid, token_kind, token_byte, byte_valid, token_last, int_value,
		start_row, start_column, error_code, input ready);
	modport sink (input valid, token_kind, token_byte, byte_valid, token_last, int_value,
		start_row, start_column, error_code, output ready);
endinterface

interface tml_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [0:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tml_step.sv @@
// next-state and token logic for one byte or end of input
`default_nettype none
module tml_step
	import tml_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF,
	parameter int INT_BITS  = INT_BITS_DEF,
	localparam int W = 6 + 8 + 1 + 1 + INT_BITS + 2 * LINE_BITS + 4
) (
	input  wire logic [7:0]           c,
	input  wire logic                 eof,
	input  wire logic                 ignore_eof,
	input  wire logic                 single_state,
	input  wire mode_t                mode_q,
	input  wire logic [LINE_BITS-1:0] line_q,
	input  wire logic [LINE_BITS-1:0] col_q,
	input  wire logic [INT_BITS-1:0]  acc_q,
	input  wire logic [7:0]           look_q,
	input  wire logic [1:0]           midx_q,
	input  wire logic [1:0]           ephase_q,
	input  wire logic [3:0]           nib_q,
	input  wire logic                 pbs_q,
	input  wire logic                 topen_q,
	input  wire logic [LINE_BITS-1:0] tok_row_q,
	input  wire logic [LINE_BITS-1:0] tok_col_q,
	input  wire logic [LINE_BITS-1:0] pend_row_q,
	input  wire logic [LINE_BITS-1:0] pend_col_q,
	input  wire logic [1:0]           wsel_q,
	input  wire logic [2:0]           wpos_q,
	output mode_t                     mode_n,
	output logic [LINE_BITS-1:0]      line_n,
	output logic [LINE_BITS-1:0]      col_n,
	output logic [INT_BITS-1:0]       acc_n,
	output logic [7:0]                look_n,
	output logic [1:0]                midx_n,
	output logic [1:0]                ephase_n,
	output logic [3:0]                nib_n,
	output logic                      pbs_n,
	output logic                      topen_n,
	output logic [LINE_BITS-1:0]      tok_row_n,
	output logic [LINE_BITS-1:0]      tok_col_n,
	output logic [LINE_BITS-1:0]      pend_row_n,
	output logic [LINE_BITS-1:0]      pend_col_n,
	output logic [1:0]                wsel_n,
	output logic [2:0]                wpos_n,
	output logic [1:0]                res_n,
	output logic [3*W-1:0]            res_flat
);

	typedef struct packed {
		logic [5:0]           kind;
		logic [7:0]           tbyte;
		logic                 bvalid;
		logic                 last;
		logic [INT_BITS-1:0]  ival;
		logic [LINE_BITS-1:0] row;
		logic [LINE_BITS-1:0] col;
		logic [3:0]           err;
	} res_t;

	function automatic res_t mk(input logic [5:0] k, input logic [7:0] b, input logic v,
		input logic l, input logic [INT_BITS-1:0] iv, input logic [LINE_BITS-1:0] r,
		input logic [LINE_BITS-1:0] cl, input logic [3:0] e);
		res_t x;
		x.kind = k; x.tbyte = b; x.bvalid = v; x.last = l;
		x.ival = iv; x.row = r; x.col = cl; x.err = e;
		return x;
	endfunction

	res_t       res [MAX_RES];
	logic [1:0] n;
	logic       do_text;
	logic       do_expr;
	logic       skip;
	logic       word_b;
	logic [5:0] qkind;
	logic [5:0] k1;
	logic [5:0] k2;
	logic [7:0] s;
	logic [5:0] sk;
	logic [7:0] ebyte;
	logic [INT_BITS-1:0] zero_i;

	assign zero_i = '0;
	assign res_n = n;
	assign res_flat = {res[2], res[1], res[0]};

	always_comb begin
		mode_n = mode_q; line_n = line_q; col_n = col_q; acc_n = acc_q; look_n = look_q;
		midx_n = midx_q; ephase_n = ephase_q; nib_n = nib_q; pbs_n = pbs_q;
		topen_n = topen_q; tok_row_n = tok_row_q; tok_col_n = tok_col_q;
		pend_row_n = pend_row_q; pend_col_n = pend_col_q; wsel_n = wsel_q; wpos_n = wpos_q;
		n = 2'd0; do_text = 1'b0; do_expr = 1'b0; skip = 1'b0; sk = K_TEXT;
		for (int i = 0; i < MAX_RES; i++) res[i] = '0;
		qkind = (look_q == "\"") ? K_STR : K_ID;
		word_b = (wsel_q != W_NONE) && (wpos_q == ((wsel_q == W_TRUE) ? 3'd4 : 3'd5));
		// held one-character operator and its two-character partner
		s = (look_q == "!") ? "=" : look_q;
		case (look_q)
			":": begin k2 = K_SCOPE; k1 = K_COLON; end
			"=": begin k2 = K_EQ; k1 = K_ASSIGN; end
			"!": begin k2 = K_NE; k1 = K_NOT; end
			"&": begin k2 = K_LAND; k1 = K_AND; end
			default: begin k2 = K_LOR; k1 = K_OR; end
		endcase
		ebyte = (ephase_q == 2'd2) ? {4'd0, nib_q} : 8'd0;

		if (mode_q == M_HALT) begin
			// halted until reset
		end else if (eof) begin
			case (mode_q)
				M_TEXT, M_TEXT_LT: begin
					if (topen_q) begin
						res[n] = mk(K_TEXT, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
						topen_n = 1'b0;
					end
					if (mode_q == M_TEXT_LT) begin
						res[n] = mk(K_LT, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
						n = n + 2'd1;
						if (ignore_eof || single_state) begin
							res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
						end else begin
							res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_EOF);
						end
					end else begin
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_ESC: begin
					if (ignore_eof) begin
						res[n] = mk(K_ESC, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end else if (single_state) begin
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end else begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_ESC);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_COMMENT: begin
					if (ignore_eof) begin
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end else begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_COMMENT);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_VERB: begin
					if (!ignore_eof) begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_VERB);
					end else begin
						if (midx_q != 2'd0) begin
							res[n] = mk(K_VERB, "|", 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
						end
						res[n] = mk(K_VERB, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_EXPR, M_OP: begin
					if (mode_q == M_OP && look_q == "<") begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_LT);
					end else if (mode_q == M_OP && look_q == ">") begin
						res[n] = mk(K_GT, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end else begin
						if (mode_q == M_OP) begin
							res[n] = mk(k1, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
							n = n + 2'd1;
						end
						if (ignore_eof || single_state) begin
							res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
						end else begin
							res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_EOF);
						end
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_QUOTE: begin
					if (!ignore_eof) begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q,
							(qkind == K_STR) ? E_STR : E_ID);
					end else begin
						if (ephase_q != 2'd0) begin
							res[n] = mk(qkind, ebyte, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
						end
						res[n] = mk(qkind, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_DEC, M_FRAC, M_HEX: begin
					if (!ignore_eof || (mode_q == M_HEX && midx_q == 2'd0)) begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NUM);
					end else begin
						if (mode_q == M_FRAC) begin
							res[n] = mk(K_FLOAT, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						end else begin
							res[n] = mk(K_INT, 8'd0, 1'b0, 1'b1, acc_q, tok_row_q, tok_col_q, E_NONE);
						end
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				M_ID: begin
					if (!ignore_eof) begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_ID);
					end else begin
						res[n] = mk(word_b ? K_BOOL : K_ID, 8'd0, 1'b0, 1'b1,
							INT_BITS'(word_b && wsel_q == W_TRUE), tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
						res[n] = mk(K_DONE, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					end
					n = n + 2'd1;
					mode_n = M_HALT;
				end
				default: begin
				end
			endcase
		end else begin
			case (mode_q)
				M_TEXT: do_text = 1'b1;
				M_TEXT_LT: begin
					if (c == " " || c inside {[8'd9:8'd13]}) begin
						if (!topen_n) begin
							topen_n = 1'b1; tok_row_n = pend_row_q; tok_col_n = pend_col_q;
						end
						res[n] = mk(K_TEXT, "<", 1'b1, 1'b0, zero_i, tok_row_n, tok_col_n, E_NONE);
						n = n + 2'd1;
						mode_n = M_TEXT;
						do_text = 1'b1;
					end else begin
						if (topen_q) begin
							res[n] = mk(K_TEXT, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
							topen_n = 1'b0;
						end
						tok_row_n = pend_row_q; tok_col_n = pend_col_q; midx_n = 2'd0;
						if (c == "!") mode_n = M_COMMENT;
						else if (c == "|") mode_n = M_VERB;
						else begin
							res[n] = mk(K_LT, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
							n = n + 2'd1;
							mode_n = M_EXPR;
							do_expr = 1'b1;
						end
					end
				end
				M_ESC: begin
					if (c == ";") begin
						res[n] = mk(K_ESC, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						mode_n = M_TEXT;
					end else begin
						res[n] = mk(K_ESC, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end
					n = n + 2'd1;
				end
				M_COMMENT: begin
					if (c == "-") begin
						if (midx_q < 2'd2) midx_n = midx_q + 2'd1;
					end else if (c == ">" && midx_q == 2'd2) begin
						midx_n = 2'd0; mode_n = M_TEXT;
					end else midx_n = 2'd0;
				end
				M_VERB: begin
					if (midx_q != 2'd0) begin
						if (c == ">") begin
							midx_n = 2'd0;
							res[n] = mk(K_VERB, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
							mode_n = M_TEXT;
						end else begin
							res[n] = mk(K_VERB, "|", 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
							if (c != "|") begin
								midx_n = 2'd0;
								res[n] = mk(K_VERB, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
								n = n + 2'd1;
							end
						end
					end else if (c == "|") midx_n = 2'd1;
					else begin
						res[n] = mk(K_VERB, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
						n = n + 2'd1;
					end
				end
				M_EXPR: do_expr = 1'b1;
				M_OP: begin
					mode_n = M_EXPR;
					if (look_q == ">" || look_q == "<") begin
						if (c == look_q || c == "=") begin
							if (c == look_q) sk = (look_q == ">") ? K_SHR : K_SHL;
							else sk = (look_q == ">") ? K_GE : K_LE;
							res[n] = mk(sk, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
							n = n + 2'd1;
						end else if (look_q == "<") begin
							res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_LT);
							n = n + 2'd1;
							mode_n = M_HALT;
						end else begin
							res[n] = mk(K_GT, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
							n = n + 2'd1;
							mode_n = M_TEXT;
							do_text = 1'b1;
						end
					end else if (c == s) begin
						res[n] = mk(k2, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
						n = n + 2'd1;
					end else begin
						res[n] = mk(k1, 8'd0, 1'b0, 1'b1, zero_i, pend_row_q, pend_col_q, E_NONE);
						n = n + 2'd1;
						do_expr = 1'b1;
					end
				end
				M_QUOTE: begin
					// pending hex escape first, then backslash, then plain bytes
					if (ephase_q != 2'd0) begin
						if (is_hex(c)) begin
							skip = 1'b1;
							if (ephase_q == 2'd1) begin
								nib_n = hex_val(c); ephase_n = 2'd2;
							end else begin
								res[n] = mk(qkind, {nib_q, hex_val(c)}, 1'b1, 1'b0, zero_i,
									tok_row_q, tok_col_q, E_NONE);
								n = n + 2'd1;
								ephase_n = 2'd0;
							end
						end else begin
							res[n] = mk(qkind, ebyte, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
							ephase_n = 2'd0;
						end
					end
					if (!skip) begin
						if (pbs_q) begin
							pbs_n = 1'b0;
							if (c == "x") ephase_n = 2'd1;
							else begin
								res[n] = mk(qkind, (c == "n") ? 8'd10 : ((c == "t") ? 8'd9 : c),
									1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
								n = n + 2'd1;
							end
						end else if (c == "\\") pbs_n = 1'b1;
						else if (c == look_q) begin
							res[n] = mk(qkind, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
							mode_n = M_EXPR;
						end else begin
							res[n] = mk(qkind, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
							n = n + 2'd1;
						end
					end
				end
				M_DEC: begin
					if (is_digit(c)) begin
						acc_n = (acc_q << 3) + (acc_q << 1) + INT_BITS'(c[3:0]);
						midx_n = 2'd0;
						res[n] = mk(K_INT, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else if ((c == "x" || c == "X") && midx_q == 2'd1) begin
						acc_n = '0; midx_n = 2'd0; mode_n = M_HEX;
						res[n] = mk(K_INT, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else if (c == ".") begin
						mode_n = M_FRAC;
						res[n] = mk(K_FLOAT, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else begin
						res[n] = mk(K_INT, 8'd0, 1'b0, 1'b1, acc_q, tok_row_q, tok_col_q, E_NONE);
						mode_n = M_EXPR; do_expr = 1'b1;
					end
					n = n + 2'd1;
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						res[n] = mk(K_FLOAT, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else begin
						res[n] = mk(K_FLOAT, 8'd0, 1'b0, 1'b1, zero_i, tok_row_q, tok_col_q, E_NONE);
						mode_n = M_EXPR; do_expr = 1'b1;
					end
					n = n + 2'd1;
				end
				M_HEX: begin
					if (is_hex(c)) begin
						acc_n = (acc_q << 4) | INT_BITS'(hex_val(c));
						midx_n = 2'd1;
						res[n] = mk(K_INT, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else if (midx_q == 2'd0) begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NUM);
						mode_n = M_HALT;
					end else begin
						res[n] = mk(K_INT, 8'd0, 1'b0, 1'b1, acc_q, tok_row_q, tok_col_q, E_NONE);
						mode_n = M_EXPR; do_expr = 1'b1;
					end
					n = n + 2'd1;
				end
				M_ID: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (wsel_q != W_NONE) begin
							if (wpos_q < ((wsel_q == W_TRUE) ? 3'd4 : 3'd5) &&
								c == word_char(wsel_q, wpos_q)) wpos_n = wpos_q + 3'd1;
							else wsel_n = W_NONE;
						end
						res[n] = mk(K_ID, c, 1'b1, 1'b0, zero_i, tok_row_q, tok_col_q, E_NONE);
					end else begin
						res[n] = mk(word_b ? K_BOOL : K_ID, 8'd0, 1'b0, 1'b1,
							INT_BITS'(word_b && wsel_q == W_TRUE), tok_row_q, tok_col_q, E_NONE);
						mode_n = M_EXPR; do_expr = 1'b1;
					end
					n = n + 2'd1;
				end
				default: begin
				end
			endcase

			// plain text byte
			if (do_text) begin
				if (c == "&") begin
					if (topen_n) begin
						res[n] = mk(K_TEXT, 8'd0, 1'b0, 1'b1, zero_i, tok_row_n, tok_col_n, E_NONE);
						n = n + 2'd1;
						topen_n = 1'b0;
					end
					tok_row_n = line_q; tok_col_n = col_q; mode_n = M_ESC;
				end else if (c == "<") begin
					pend_row_n = line_q; pend_col_n = col_q; mode_n = M_TEXT_LT;
				end else begin
					if (!topen_n) begin
						topen_n = 1'b1; tok_row_n = line_q; tok_col_n = col_q;
					end
					res[n] = mk(K_TEXT, c, 1'b1, 1'b0, zero_i, tok_row_n, tok_col_n, E_NONE);
					n = n + 2'd1;
				end
			end

			// byte between command tokens
			if (do_expr) begin
				pend_row_n = line_q; pend_col_n = col_q;
				sk = K_TEXT;
				case (c)
					"+": sk = K_PLUS;
					"-": sk = K_MINUS;
					"/": sk = K_SLASH;
					"%": sk = K_PCT;
					"*": sk = K_STAR;
					"?": sk = K_QMARK;
					",": sk = K_COMMA;
					".": sk = K_DOT;
					"(": sk = K_LPAREN;
					")": sk = K_RPAREN;
					"[": sk = K_LBRACK;
					"]": sk = K_RBRACK;
					"{": sk = K_LBRACE;
					"}": sk = K_RBRACE;
					default: sk = K_TEXT;
				endcase
				if (c inside {" ", 8'd10, 8'd9}) begin
					// skipped
				end else if (c inside {">", "<", ":", "=", "!", "&", "|"}) begin
					look_n = c; mode_n = M_OP;
				end else if (c == "'" || c == "\"") begin
					look_n = c; tok_row_n = line_q; tok_col_n = col_q;
					pbs_n = 1'b0; ephase_n = 2'd0; mode_n = M_QUOTE;
				end else if (sk != K_TEXT) begin
					res[n] = mk(sk, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_NONE);
					n = n + 2'd1;
				end else begin
					tok_row_n = line_q; tok_col_n = col_q;
					if (is_digit(c)) begin
						acc_n = INT_BITS'(c[3:0]);
						midx_n = (c == "0") ? 2'd1 : 2'd0;
						mode_n = M_DEC;
						res[n] = mk(K_INT, c, 1'b1, 1'b0, zero_i, line_q, col_q, E_NONE);
					end else if (is_alpha(c)) begin
						wsel_n = (c == "t") ? W_TRUE : ((c == "f") ? W_FALSE : W_NONE);
						wpos_n = 3'd1;
						mode_n = M_ID;
						res[n] = mk(K_ID, c, 1'b1, 1'b0, zero_i, line_q, col_q, E_NONE);
					end else begin
						res[n] = mk(K_ERR, 8'd0, 1'b0, 1'b1, zero_i, line_q, col_q, E_CHAR);
						mode_n = M_HALT;
					end
					n = n + 2'd1;
				end
			end

			// position of the next byte
			if (c == 8'd10) begin
				line_n = line_q + 1'b1; col_n = '0;
			end else begin
				col_n = col_q + ((c == 8'd9) ? LINE_BITS'(8) : LINE_BITS'(1));
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tml_fifo.sv @@
// result queue: up to three writes per cycle, one read
`default_nettype none
module tml_fifo
	import tml_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       wr_n,
	input  wire logic [3*W-1:0]   wr_data,
	input  wire logic             rd,
	output logic [W-1:0]          rd_data,
	output logic                  not_empty,
	output logic                  room
);

	localparam int PW = $clog2(FIFO_DEPTH);

	logic [W-1:0]  mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign pop       = rd && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign room      = (count_q <= (PW+1)'(FIFO_DEPTH - MAX_RES));
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < wr_n) mem_q[PW'(wr_ptr_q + PW'(i))] <= wr_data[i*W +: W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(wr_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(wr_n) - (PW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/template_markup_lexer.sv @@
// top level of the template markup lexer
// usage:
//   byte_ch  - one item per template byte (in_byte, end_of_input); valid/ready
//   token_ch - one item per result: kind, body byte, last flag, integer value,
//              start row/column and error code; valid/ready
//   cfg      - register writes (index 0 ignore_eof, index 1 single_state),
//              always ready; write only while the block is idle
// each byte is lexed in the cycle it is accepted and gives zero to three
// results, written to a four-entry result queue; the first result shows on
// token_ch once the results queued ahead of it have been read
// throughput: one byte per cycle while each byte gives at most one result and
// the receiver keeps up; byte_ch is ready whenever the queue has room for
// three results, so bytes giving several results are paced by the one-per-cycle
// drain of token_ch
// receiver stall: results wait in the queue, byte_ch drops ready when fewer
// than three free entries remain
// after done or an error every further byte is taken and ignored
// reset: text mode, row one, column zero, queue empty, both registers cleared
`default_nettype none
module template_markup_lexer
	import tml_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF,
	parameter int INT_BITS  = INT_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tml_in_if.sink     byte_ch,
	tml_out_if.source  token_ch,
	tml_cfg_if.sink    cfg
);

	localparam int W = 6 + 8 + 1 + 1 + INT_BITS + 2 * LINE_BITS + 4;

	typedef struct packed {
		logic [5:0]           kind;
		logic [7:0]           tbyte;
		logic                 bvalid;
		logic                 last;
		logic [INT_BITS-1:0]  ival;
		logic [LINE_BITS-1:0] row;
		logic [LINE_BITS-1:0] col;
		logic [3:0]           err;
	} res_t;

	// configuration registers
	logic ignore_eof_q;
	logic single_state_q;

	// lexer state
	mode_t                mode_q, mode_n;
	logic [LINE_BITS-1:0] line_q, line_n, col_q, col_n;
	logic [INT_BITS-1:0]  acc_q, acc_n;
	logic [7:0]           look_q, look_n;
	logic [1:0]           midx_q, midx_n, ephase_q, ephase_n;
	logic [3:0]           nib_q, nib_n;
	logic                 pbs_q, pbs_n, topen_q, topen_n;
	logic [LINE_BITS-1:0] tok_row_q, tok_row_n, tok_col_q, tok_col_n;
	logic [LINE_BITS-1:0] pend_row_q, pend_row_n, pend_col_q, pend_col_n;
	logic [1:0]           wsel_q, wsel_n;
	logic [2:0]           wpos_q, wpos_n;

	logic [1:0]     res_n;
	logic [3*W-1:0] res_flat;
	logic           accept;
	logic           room;
	logic           not_empty;
	logic [W-1:0]   head;
	res_t           head_r;

	assign cfg.ready     = 1'b1;
	assign byte_ch.ready = room;
	assign accept        = byte_ch.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_eof_q   <= 1'b0;
			single_state_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_IGNORE_EOF:   ignore_eof_q   <= cfg.data[0];
				CFG_SINGLE_STATE: single_state_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	tml_step #(
		.LINE_BITS (LINE_BITS),
		.INT_BITS  (INT_BITS)
	) u_step (
		.c            (byte_ch.in_byte),
		.eof          (byte_ch.end_of_input),
		.ignore_eof   (ignore_eof_q),
		.single_state (single_state_q),
		.mode_q, .line_q, .col_q, .acc_q, .look_q, .midx_q, .ephase_q, .nib_q,
		.pbs_q, .topen_q, .tok_row_q, .tok_col_q, .pend_row_q, .pend_col_q,
		.wsel_q, .wpos_q,
		.mode_n, .line_n, .col_n, .acc_n, .look_n, .midx_n, .ephase_n, .nib_n,
		.pbs_n, .topen_n, .tok_row_n, .tok_col_n, .pend_row_n, .pend_col_n,
		.wsel_n, .wpos_n,
		.res_n, .res_flat
	);

	// state register, updated once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_TEXT;
			line_q     <= LINE_BITS'(1);
			col_q      <= '0;
			acc_q      <= '0;
			look_q     <= '0;
			midx_q     <= '0;
			ephase_q   <= '0;
			nib_q      <= '0;
			pbs_q      <= 1'b0;
			topen_q    <= 1'b0;
			tok_row_q  <= '0;
			tok_col_q  <= '0;
			pend_row_q <= '0;
			pend_col_q <= '0;
			wsel_q     <= W_NONE;
			wpos_q     <= '0;
		end else if (accept) begin
			mode_q     <= mode_n;
			line_q     <= line_n;
			col_q      <= col_n;
			acc_q      <= acc_n;
			look_q     <= look_n;
			midx_q     <= midx_n;
			ephase_q   <= ephase_n;
			nib_q      <= nib_n;
			pbs_q      <= pbs_n;
			topen_q    <= topen_n;
			tok_row_q  <= tok_row_n;
			tok_col_q  <= tok_col_n;
			pend_row_q <= pend_row_n;
			pend_col_q <= pend_col_n;
			wsel_q     <= wsel_n;
			wpos_q     <= wpos_n;
		end
	end

	// result queue decouples the lexer from the receiver
	tml_fifo #(
		.W (W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_n      (accept ? res_n : 2'd0),
		.wr_data   (res_flat),
		.rd        (token_ch.ready),
		.rd_data   (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign head_r                = res_t'(head);
	assign token_ch.valid        = not_empty;
	assign token_ch.token_kind   = head_r.kind;
	assign token_ch.token_byte   = head_r.tbyte;
	assign token_ch.byte_valid   = head_r.bvalid;
	assign token_ch.token_last   = head_r.last;
	assign token_ch.int_value    = head_r.ival;
	assign token_ch.start_row    = head_r.row;
	assign token_ch.start_column = head_r.col;
	assign token_ch.error_code   = head_r.err;

endmodule
`default_nettype wire

@@ rtl/core/tml_check.sv @@
// port-level checks for the template markup lexer, bound to the top level
`default_nettype none
module tml_check
	import tml_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] kind,
	input wire logic [7:0] tbyte,
	input wire logic       bvalid,
	input wire logic       last,
	input wire logic [3:0] err
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == K_ERR) == (err != E_NONE)))
		else $error("error code does not match kind");

	a_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bvalid |-> !last)
		else $error("body byte marked last");

	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bvalid |-> (tbyte == 8'd0) && last)
		else $error("closing result carries a byte or is not last");

endmodule

bind template_markup_lexer tml_check u_tml_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (token_ch.valid),
	.out_ready (token_ch.ready),
	.kind      (token_ch.token_kind),
	.tbyte     (token_ch.token_byte),
	.bvalid    (token_ch.byte_valid),
	.last      (token_ch.token_last),
	.err       (token_ch.error_code)
);
`default_nettype wire
